// ===== hdl/ljpf_pkg.sv =====
// Shared types and constants for the 2D Lennard-Jones pair force block.
// Command and result beat layouts, register indexes, fixed-point limits.
// No dependencies.
package ljpf_pkg;

  localparam int unsigned MaxAtomsDef = 64;

  // command codes
  localparam logic [1:0] CmdLoad    = 2'd0;
  localparam logic [1:0] CmdCompute = 2'd1;
  localparam logic [1:0] CmdRead    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CfgAtomCount = 2'd0;
  localparam logic [1:0] CfgRegionX   = 2'd1;
  localparam logic [1:0] CfgRegionY   = 2'd2;
  localparam logic [1:0] CfgCutoff    = 2'd3;

  localparam logic [6:0]  AtomCountRst = 7'd2;
  localparam logic [22:0] RegionRst    = 23'd655360;
  localparam logic [22:0] CutoffRst    = 23'd73562;

  localparam logic [63:0] OneQ32  = 64'h0000_0001_0000_0000;
  localparam logic [63:0] HalfQ32 = 64'h0000_0000_8000_0000;
  localparam logic [63:0] MaxU64  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [50:0] MagClamp = 51'h4_0000_0000_0000;

  localparam logic signed [47:0] AccMax = 48'sd2147483647;
  localparam logic signed [47:0] AccMin = -48'sd2147483648;
  localparam logic signed [47:0] SumMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SumMin = 48'sh8000_0000_0000;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [5:0]         atom_index;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
  } lj_in_t;

  typedef struct packed {
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [47:0] potential_total;
    logic signed [47:0] virial_total;
    logic               overflow_flag;
  } lj_out_t;

  typedef enum logic [25:0] {
    ST_IDLE = 26'h0000001,
    ST_RD0  = 26'h0000002,
    ST_RD1  = 26'h0000004,
    ST_CLR  = 26'h0000008,
    ST_MUL  = 26'h0000010,
    ST_RC2  = 26'h0000020,
    ST_PRDI = 26'h0000040,
    ST_PRDJ = 26'h0000080,
    ST_WRAP = 26'h0000100,
    ST_SQX  = 26'h0000200,
    ST_SQY  = 26'h0000400,
    ST_CHK  = 26'h0000800,
    ST_DIV  = 26'h0001000,
    ST_T1   = 26'h0002000,
    ST_RI6  = 26'h0004000,
    ST_UU   = 26'h0008000,
    ST_VV   = 26'h0010000,
    ST_TX   = 26'h0020000,
    ST_TY   = 26'h0040000,
    ST_WW   = 26'h0080000,
    ST_VR   = 26'h0100000,
    ST_AI0  = 26'h0200000,
    ST_AI1  = 26'h0400000,
    ST_AJ0  = 26'h0800000,
    ST_AJ1  = 26'h1000000,
    ST_NEXT = 26'h2000000
  } state_e;

endpackage

// ===== hdl/lj_pair_force_periodic_2d.sv =====
// Top level of the 2D Lennard-Jones pair force block (minimum image, periodic box).
// Holds the position and acceleration memories and the pair sequencer.
// Depends on ljpf_pkg.
//
// Use: a command beat is taken when start is high and busy is low.
//   Load writes one position and keeps busy low; the next beat may follow at once.
//   Read returns one beat on result_o, strobed by result_valid_o for one cycle,
//   once it has passed the RD0 and RD1 states. The receiver cannot stall; the beat
//   is gone after that cycle.
//   Compute clears MAX_ATOMS accelerations (one per cycle), squares the cutoff
//   and then walks the pairs one at a time. A pair within the cutoff also runs
//   the 64-step radix-2 divider for 1/r^2; all products go through the one
//   shared 32x32 multiplier.
//   Busy stays high until the walk ends; compute gives no result beat.
// Config: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i, one register
//   a beat, accepted while the block is idle.
// Reset: control and sums clear and the config registers take their reset values at once;
//   there is no clearing pass, the stores are undefined until written.
module lj_pair_force_periodic_2d #(
  parameter int unsigned MAX_ATOMS = ljpf_pkg::MaxAtomsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  ljpf_pkg::lj_in_t  cmd_i,
  output logic            result_valid_o,
  output ljpf_pkg::lj_out_t result_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [22:0]     cfg_data_i
);
  import ljpf_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ATOMS);
  localparam int unsigned CW = $clog2(MAX_ATOMS + 1);
  localparam logic [AW-1:0] LastSlot = AW'(MAX_ATOMS - 1);

  // memories
  logic signed [23:0] pos_x_mem [MAX_ATOMS];
  logic signed [23:0] pos_y_mem [MAX_ATOMS];
  logic signed [31:0] acc_x_mem [MAX_ATOMS];
  logic signed [31:0] acc_y_mem [MAX_ATOMS];
  logic signed [23:0] pos_x_rd_q, pos_y_rd_q;
  logic signed [31:0] acc_x_rd_q, acc_y_rd_q;

  // config
  logic [6:0]  atom_count_q;
  logic [22:0] region_x_q, region_y_q, cutoff_q;

  // control
  state_e          state_q, ret_q;
  logic [AW-1:0]   i_q, j_q, clr_q, rd_addr_q;
  logic            rd_ok_q;
  logic [CW-1:0]   n_q;
  logic            sat_q;
  logic signed [47:0] pot_q, vir_q;
  logic            res_valid_q;
  lj_out_t         res_q;

  // multiplier
  logic [63:0] ma_q, mb_q, prod_q, mres_q;
  logic [65:0] macc_q, msum;
  logic [2:0]  ms_q;
  logic        mov_q, mflag;
  logic [31:0] mop_a, mop_b;
  logic [63:0] mfinal;

  // divider
  logic [46:0] rem_q, trial;
  logic [5:0]  dcnt_q;
  logic        div_bit;
  logic [63:0] ri2_nx;

  // pair datapath
  logic signed [23:0] xi_q, yi_q;
  logic [24:0]  ax_q, ay_q;
  logic         sx_q, sy_q, fneg_q;
  logic [45:0]  rc2_q;
  logic [50:0]  r2_q;
  logic [63:0]  ri2_q, ri6_q, fmag_q, tx_q, ty_q;

  logic               accept, idx_ok;
  logic [31:0]        idx_w;
  logic [AW-1:0]      idx_addr;
  logic [AW-1:0]      pos_raddr, acc_raddr, acc_waddr;
  logic               acc_we;
  logic signed [31:0] acc_wx, acc_wy;
  logic               acc_flag;
  logic               done_row, last_pair;
  logic signed [25:0] dx_c, dy_c;
  logic [24:0]        ax_c, ay_c;
  logic [63:0]        hmag_c, qmag_c, fmag_c, t4_c, potv_c;
  logic [69:0]        v48_c;
  logic [65:0]        v4_c;
  logic [64:0]        psum_c;
  logic               f48_flag, pot_flag;
  logic [48:0]        pot_add, vir_add, ax_add, ay_add;
  logic               neg_x, neg_y;
  logic [31:0]        cnt_w;

  function automatic logic signed [25:0] wrap_axis(logic signed [24:0] d, logic [22:0] r);
    logic signed [26:0] dd, rr;
    dd = 27'(d);
    rr = $signed({4'b0, r});
    if ((dd <<< 1) >= rr) wrap_axis = 26'(dd - rr);
    else if ((dd <<< 1) < -rr) wrap_axis = 26'(dd + rr);
    else wrap_axis = 26'(dd);
  endfunction

  // returns {saturated, value}; magnitude clamped to 2^50 first
  function automatic logic [48:0] sat_add(logic signed [47:0] acc, logic neg,
                                          logic [63:0] mag, logic signed [47:0] lo,
                                          logic signed [47:0] hi);
    logic [50:0] m;
    logic signed [51:0] s;
    m = (mag > 64'(MagClamp)) ? MagClamp : 51'(mag);
    s = neg ? 52'(acc) - $signed({1'b0, m}) : 52'(acc) + $signed({1'b0, m});
    if (s > 52'(hi)) sat_add = {1'b1, hi};
    else if (s < 52'(lo)) sat_add = {1'b1, lo};
    else sat_add = {1'b0, s[47:0]};
  endfunction

  assign busy           = (state_q != ST_IDLE);
  assign accept         = start && !busy;
  assign cfg_ready_o    = !busy;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  assign idx_w    = 32'(cmd_i.atom_index);
  assign idx_addr = idx_w[AW-1:0];
  assign idx_ok   = idx_w < MAX_ATOMS;
  assign cnt_w    = (32'(atom_count_q) > MAX_ATOMS) ? MAX_ATOMS : 32'(atom_count_q);

  // shared 32x32 multiplier, four partial products per Q32.32 product
  assign mop_a  = (ms_q == 3'd0 || ms_q == 3'd1) ? ma_q[63:32] : ma_q[31:0];
  assign mop_b  = (ms_q == 3'd0 || ms_q == 3'd2) ? mb_q[63:32] : mb_q[31:0];
  assign msum   = macc_q + 66'(prod_q[63:32]);
  assign mflag  = mov_q || (msum[65:64] != 2'b00);
  assign mfinal = mflag ? MaxU64 : msum[63:0];

  // restoring divide of all-ones by r^2
  assign trial   = {rem_q[45:0], 1'b1};
  assign div_bit = trial >= 47'(r2_q);
  assign ri2_nx  = {ri2_q[62:0], div_bit};

  assign dx_c = wrap_axis(25'(xi_q) - 25'(pos_x_rd_q), region_x_q);
  assign dy_c = wrap_axis(25'(yi_q) - 25'(pos_y_rd_q), region_y_q);
  assign ax_c = dx_c[25] ? 25'(-dx_c) : 25'(dx_c);
  assign ay_c = dy_c[25] ? 25'(-dy_c) : 25'(dy_c);

  assign hmag_c   = (mres_q < HalfQ32) ? HalfQ32 - mres_q : mres_q - HalfQ32;
  assign qmag_c   = (ri6_q < OneQ32) ? OneQ32 - ri6_q : ri6_q - OneQ32;
  assign v48_c    = ({6'b0, mres_q} << 5) + ({6'b0, mres_q} << 4);
  assign f48_flag = v48_c[69:64] != 6'b0;
  assign fmag_c   = f48_flag ? MaxU64 : v48_c[63:0];

  // shifted pair potential
  always_comb begin
    v4_c   = {2'b0, mres_q} << 2;
    t4_c   = (v4_c[65:64] != 2'b00) ? MaxU64 : v4_c[63:0];
    psum_c = {1'b0, t4_c} + 65'(OneQ32);
    pot_flag = v4_c[65:64] != 2'b00;
    if (ri6_q < OneQ32) begin
      potv_c = (t4_c > OneQ32) ? 64'd0 : OneQ32 - t4_c;
    end else begin
      potv_c = psum_c[64] ? MaxU64 : psum_c[63:0];
      if (psum_c[64]) pot_flag = 1'b1;
    end
  end

  assign pot_add = sat_add(pot_q, 1'b0, potv_c >> 16, SumMin, SumMax);
  assign vir_add = sat_add(vir_q, fneg_q, mres_q >> 16, SumMin, SumMax);

  assign neg_x  = (state_q == ST_AI1) ? (fneg_q != sx_q) : (fneg_q == sx_q);
  assign neg_y  = (state_q == ST_AI1) ? (fneg_q != sy_q) : (fneg_q == sy_q);
  assign ax_add = sat_add(48'(acc_x_rd_q), neg_x, tx_q, AccMin, AccMax);
  assign ay_add = sat_add(48'(acc_y_rd_q), neg_y, ty_q, AccMin, AccMax);
  assign acc_flag = ax_add[48] || ay_add[48];

  assign done_row  = (32'(j_q) + 32'd1) == 32'(n_q);
  assign last_pair = done_row && ((32'(i_q) + 32'd2) == 32'(n_q));

  always_comb begin
    pos_raddr = (state_q == ST_PRDI) ? i_q : j_q;
    case (state_q)
      ST_RD0:  acc_raddr = rd_addr_q;
      ST_AI0:  acc_raddr = i_q;
      default: acc_raddr = j_q;
    endcase
    acc_we = (state_q == ST_CLR) || (state_q == ST_AI1) || (state_q == ST_AJ1);
    case (state_q)
      ST_CLR:  acc_waddr = clr_q;
      ST_AI1:  acc_waddr = i_q;
      default: acc_waddr = j_q;
    endcase
    acc_wx = (state_q == ST_CLR) ? 32'sd0 : ax_add[31:0];
    acc_wy = (state_q == ST_CLR) ? 32'sd0 : ay_add[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (accept && cmd_i.cmd == CmdLoad && idx_ok) begin
      pos_x_mem[idx_addr] <= cmd_i.pos_x;
      pos_y_mem[idx_addr] <= cmd_i.pos_y;
    end
    pos_x_rd_q <= pos_x_mem[pos_raddr];
    pos_y_rd_q <= pos_y_mem[pos_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_x_mem[acc_waddr] <= acc_wx;
      acc_y_mem[acc_waddr] <= acc_wy;
    end
    acc_x_rd_q <= acc_x_mem[acc_raddr];
    acc_y_rd_q <= acc_y_mem[acc_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;      ret_q <= ST_IDLE;
      atom_count_q <= AtomCountRst;
      region_x_q <= RegionRst; region_y_q <= RegionRst; cutoff_q <= CutoffRst;
      i_q <= '0; j_q <= '0; clr_q <= '0; rd_addr_q <= '0; rd_ok_q <= 1'b0;
      n_q <= '0; sat_q <= 1'b0; pot_q <= '0; vir_q <= '0;
      res_valid_q <= 1'b0; res_q <= '0;
      ma_q <= '0; mb_q <= '0; prod_q <= '0; mres_q <= '0; macc_q <= '0;
      ms_q <= '0; mov_q <= 1'b0;
      rem_q <= '0; dcnt_q <= '0;
      xi_q <= '0; yi_q <= '0; ax_q <= '0; ay_q <= '0;
      sx_q <= 1'b0; sy_q <= 1'b0; fneg_q <= 1'b0;
      rc2_q <= '0; r2_q <= '0;
      ri2_q <= '0; ri6_q <= '0; fmag_q <= '0; tx_q <= '0; ty_q <= '0;
    end else begin
      res_valid_q <= 1'b0;

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgAtomCount: atom_count_q <= cfg_data_i[6:0];
          CfgRegionX:   region_x_q   <= cfg_data_i;
          CfgRegionY:   region_y_q   <= cfg_data_i;
          CfgCutoff:    cutoff_q     <= cfg_data_i;
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (cmd_i.cmd == CmdRead) begin
              rd_addr_q <= idx_addr;
              rd_ok_q   <= idx_ok;
              state_q   <= ST_RD0;
            end else if (cmd_i.cmd == CmdCompute) begin
              n_q     <= CW'(cnt_w);
              clr_q   <= '0;
              sat_q   <= 1'b0;
              pot_q   <= '0;
              vir_q   <= '0;
              state_q <= ST_CLR;
            end
          end
        end
        ST_RD0: state_q <= ST_RD1;
        ST_RD1: begin
          res_q.accel_x         <= rd_ok_q ? acc_x_rd_q : 32'sd0;
          res_q.accel_y         <= rd_ok_q ? acc_y_rd_q : 32'sd0;
          res_q.potential_total <= pot_q;
          res_q.virial_total    <= vir_q;
          res_q.overflow_flag   <= sat_q;
          res_valid_q           <= 1'b1;
          state_q               <= ST_IDLE;
        end
        ST_CLR: begin
          if (clr_q == LastSlot) begin
            ma_q <= {9'b0, cutoff_q, 32'b0}; mb_q <= 64'(cutoff_q);
            ms_q <= '0; ret_q <= ST_RC2; state_q <= ST_MUL;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        ST_MUL: begin
          prod_q <= mop_a * mop_b;
          ms_q   <= ms_q + 3'd1;
          case (ms_q)
            3'd1: begin
              macc_q <= {2'b0, prod_q[31:0], 32'b0};
              mov_q  <= prod_q[63:32] != 32'b0;
            end
            3'd2, 3'd3: macc_q <= macc_q + 66'(prod_q);
            3'd4: begin
              mres_q  <= mfinal;
              if (mflag) sat_q <= 1'b1;
              state_q <= ret_q;
            end
            default: ;
          endcase
        end
        ST_RC2: begin
          rc2_q <= mres_q[45:0];
          i_q   <= '0;
          j_q   <= AW'(1);
          state_q <= (32'(n_q) < 32'd2) ? ST_IDLE : ST_PRDI;
        end
        ST_PRDI: state_q <= ST_PRDJ;
        ST_PRDJ: begin
          xi_q <= pos_x_rd_q;
          yi_q <= pos_y_rd_q;
          state_q <= ST_WRAP;
        end
        ST_WRAP: begin
          ax_q <= ax_c; ay_q <= ay_c;
          sx_q <= dx_c[25]; sy_q <= dy_c[25];
          ma_q <= {7'b0, ax_c, 32'b0}; mb_q <= 64'(ax_c);
          ms_q <= '0; ret_q <= ST_SQX; state_q <= ST_MUL;
        end
        ST_SQX: begin
          r2_q <= 51'(mres_q);
          ma_q <= {7'b0, ay_q, 32'b0}; mb_q <= 64'(ay_q);
          ms_q <= '0; ret_q <= ST_SQY; state_q <= ST_MUL;
        end
        ST_SQY: begin
          r2_q    <= r2_q + 51'(mres_q);
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          if (r2_q >= 51'(rc2_q)) begin
            state_q <= ST_NEXT;
          end else if (r2_q == '0) begin
            sat_q   <= 1'b1;
            state_q <= ST_NEXT;
          end else begin
            rem_q <= '0; ri2_q <= '0; dcnt_q <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q  <= div_bit ? trial - 47'(r2_q) : trial;
          ri2_q  <= ri2_nx;
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == 6'd63) begin
            ma_q <= ri2_nx; mb_q <= ri2_nx;
            ms_q <= '0; ret_q <= ST_T1; state_q <= ST_MUL;
          end
        end
        ST_T1: begin
          ma_q <= mres_q; mb_q <= ri2_q;
          ms_q <= '0; ret_q <= ST_RI6; state_q <= ST_MUL;
        end
        ST_RI6: begin
          ri6_q  <= mres_q;
          fneg_q <= mres_q < HalfQ32;
          ma_q <= mres_q; mb_q <= hmag_c;
          ms_q <= '0; ret_q <= ST_UU; state_q <= ST_MUL;
        end
        ST_UU: begin
          ma_q <= mres_q; mb_q <= ri2_q;
          ms_q <= '0; ret_q <= ST_VV; state_q <= ST_MUL;
        end
        ST_VV: begin
          fmag_q <= fmag_c;
          if (f48_flag) sat_q <= 1'b1;
          ma_q <= fmag_c; mb_q <= 64'(ax_q);
          ms_q <= '0; ret_q <= ST_TX; state_q <= ST_MUL;
        end
        ST_TX: begin
          tx_q <= mres_q;
          ma_q <= fmag_q; mb_q <= 64'(ay_q);
          ms_q <= '0; ret_q <= ST_TY; state_q <= ST_MUL;
        end
        ST_TY: begin
          ty_q <= mres_q;
          ma_q <= ri6_q; mb_q <= qmag_c;
          ms_q <= '0; ret_q <= ST_WW; state_q <= ST_MUL;
        end
        ST_WW: begin
          pot_q <= pot_add[47:0];
          if (pot_flag || pot_add[48]) sat_q <= 1'b1;
          ma_q <= fmag_q; mb_q <= 64'(r2_q);
          ms_q <= '0; ret_q <= ST_VR; state_q <= ST_MUL;
        end
        ST_VR: begin
          vir_q <= vir_add[47:0];
          if (vir_add[48]) sat_q <= 1'b1;
          state_q <= ST_AI0;
        end
        ST_AI0: state_q <= ST_AI1;
        ST_AI1: begin
          if (acc_flag) sat_q <= 1'b1;
          state_q <= ST_AJ0;
        end
        ST_AJ0: state_q <= ST_AJ1;
        ST_AJ1: begin
          if (acc_flag) sat_q <= 1'b1;
          state_q <= ST_NEXT;
        end
        ST_NEXT: begin
          if (last_pair) begin
            state_q <= ST_IDLE;
          end else if (done_row) begin
            i_q <= i_q + 1'b1;
            j_q <= AW'(32'(i_q) + 32'd2);
            state_q <= ST_PRDI;
          end else begin
            j_q <= j_q + 1'b1;
            state_q <= ST_PRDI;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // a read beat comes out after the RD0 and RD1 states once it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i.cmd == CmdRead) |-> ##3 result_valid_o)
    else $error("read result beat missing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  // divider only runs on a non-zero r^2 inside the cutoff
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (r2_q != '0 && r2_q < 51'(rc2_q)))
    else $error("divider started on a bad operand");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NEXT) |-> (i_q < j_q && 32'(j_q) < 32'(n_q)))
    else $error("pair indices out of order");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (ms_q <= 3'd4))
    else $error("multiplier step counter overran");

endmodule

// ===== tb/sv/tb_lj_pair_force_periodic_2d.sv =====
`timescale 1ns / 1ps
// Testbench for lj_pair_force_periodic_2d: a directed table, then randomised phases.
// Read beats are checked against a bit-accurate pair force predictor kept in this file;
// typed directed rows against their table beat. Depends on ljpf_pkg and the block's RTL.
module tb_lj_pair_force_periodic_2d;
  import ljpf_pkg::*;

  localparam int unsigned NAtoms = 64;
  localparam longint unsigned CycleLimit = 8000000;
  localparam logic [63:0] MagCap = 64'h0004_0000_0000_0000;

  typedef struct {
    lj_in_t  beat;
    bit      typed;
    lj_out_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  lj_in_t      cmd_i = '0;
  logic        result_valid_o;
  lj_out_t     result_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CfgAtomCount;
  logic [22:0] cfg_data_i = '0;

  lj_out_t read_q[$];
  int unsigned errors = 0;
  longint unsigned cycles = 0;

  // predictor state
  longint pos_x[NAtoms];
  longint pos_y[NAtoms];
  longint acc_x[NAtoms];
  longint acc_y[NAtoms];
  longint pot_sum, vir_sum;
  bit     sat;
  logic [6:0]  n_atoms;
  logic [22:0] box_x, box_y, r_cut;

  lj_pair_force_periodic_2d dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .result_valid_o, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------- predictor ----------------
  function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> 32;
    if (p[127:64] != 0) begin
      sat = 1'b1;
      return '1;
    end
    return p[63:0];
  endfunction

  function automatic logic [63:0] k_mul(logic [63:0] a, int unsigned k);
    logic [127:0] p;
    p = {64'd0, a} * k;
    if (p[127:64] != 0) begin
      sat = 1'b1;
      return '1;
    end
    return p[63:0];
  endfunction

  function automatic logic [63:0] u_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[64]) begin
      sat = 1'b1;
      return '1;
    end
    return s[63:0];
  endfunction

  function automatic longint clamp_add(longint acc, bit neg, logic [63:0] mag,
                                       longint lo, longint hi);
    longint s;
    if (mag > MagCap) mag = MagCap;
    s = neg ? acc - longint'(mag) : acc + longint'(mag);
    if (s > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (s < lo) begin
      sat = 1'b1;
      return lo;
    end
    return s;
  endfunction

  // single minimum-image wrap per axis
  function automatic longint min_image(longint d, longint r);
    if (2 * d >= r) return d - r;
    if (2 * d < -r) return d + r;
    return d;
  endfunction

  function automatic void pair_force(int i, int j, logic [63:0] rc2);
    longint dx, dy;
    logic [63:0] ax, ay, r2, ri2, ri6, hmag, fmag, t, pot, tx, ty, vir;
    bit fneg, qneg;
    dx = min_image(pos_x[i] - pos_x[j], longint'(box_x));
    dy = min_image(pos_y[i] - pos_y[j], longint'(box_y));
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    r2 = ax * ax + ay * ay;
    if (r2 >= rc2) return;
    if (r2 == 0) begin
      sat = 1'b1;  // coincident atoms
      return;
    end
    ri2 = MaxU64 / r2;
    ri6 = q_mul(q_mul(ri2, ri2), ri2);
    fneg = ri6 < HalfQ32;
    hmag = fneg ? HalfQ32 - ri6 : ri6 - HalfQ32;
    fmag = k_mul(q_mul(q_mul(ri6, hmag), ri2), 48);
    tx = q_mul(fmag, ax);
    ty = q_mul(fmag, ay);
    acc_x[i] = clamp_add(acc_x[i], fneg != (dx < 0), tx, AccMin, AccMax);
    acc_y[i] = clamp_add(acc_y[i], fneg != (dy < 0), ty, AccMin, AccMax);
    acc_x[j] = clamp_add(acc_x[j], fneg == (dx < 0), tx, AccMin, AccMax);
    acc_y[j] = clamp_add(acc_y[j], fneg == (dy < 0), ty, AccMin, AccMax);
    qneg = ri6 < OneQ32;
    t = k_mul(q_mul(ri6, qneg ? OneQ32 - ri6 : ri6 - OneQ32), 4);
    if (qneg) pot = (t > OneQ32) ? 64'd0 : OneQ32 - t;
    else pot = u_add(t, OneQ32);
    pot_sum = clamp_add(pot_sum, 1'b0, pot >> 16, SumMin, SumMax);
    vir = q_mul(fmag, r2) >> 16;
    vir_sum = clamp_add(vir_sum, fneg, vir, SumMin, SumMax);
  endfunction

  function automatic void walk_pairs();
    int n;
    logic [63:0] rc2;
    n = (n_atoms > NAtoms) ? NAtoms : int'(n_atoms);
    rc2 = 64'(r_cut) * 64'(r_cut);
    foreach (acc_x[k]) begin
      acc_x[k] = 0;
      acc_y[k] = 0;
    end
    pot_sum = 0;
    vir_sum = 0;
    sat = 1'b0;
    for (int i = 0; i + 1 < n; i++)
      for (int j = i + 1; j < n; j++) pair_force(i, j, rc2);
  endfunction

  // apply one accepted beat; for a read, returns 1 and gives the predicted beat in o
  function automatic bit apply_beat(lj_in_t b, output lj_out_t o);
    o = '0;
    case (b.cmd)
      CmdLoad: begin
        pos_x[b.atom_index] = longint'(b.pos_x);
        pos_y[b.atom_index] = longint'(b.pos_y);
      end
      CmdCompute: walk_pairs();
      CmdRead: begin
        o.accel_x = acc_x[b.atom_index][31:0];
        o.accel_y = acc_y[b.atom_index][31:0];
        o.potential_total = pot_sum[47:0];
        o.virial_total = vir_sum[47:0];
        o.overflow_flag = sat;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // ---------------- result check ----------------
  task automatic cmp_field(string name, logic [47:0] e, logic [47:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (read_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, got %h", $time, result_o);
      end else begin
        lj_out_t e;
        e = read_q.pop_front();
        cmp_field("accel_x", 48'(e.accel_x), 48'(result_o.accel_x));
        cmp_field("accel_y", 48'(e.accel_y), 48'(result_o.accel_y));
        cmp_field("potential_total", e.potential_total, result_o.potential_total);
        cmp_field("virial_total", e.virial_total, result_o.virial_total);
        cmp_field("overflow_flag", 48'(e.overflow_flag), 48'(result_o.overflow_flag));
      end
    end
  end

  // ---------------- drivers ----------------
  // called at a rising edge; returns at the edge the beat is taken
  task automatic issue(lj_in_t b, bit typed, lj_out_t want);
    lj_out_t o;
    start <= 1'b1;
    cmd_i <= b;
    do @(posedge clk_i); while (busy);
    if (apply_beat(b, o)) read_q.push_back(typed ? want : o);
  endtask

  task automatic gap(int unsigned n);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (busy || read_q.size() != 0);
    repeat (8) @(posedge clk_i);  // read pipeline and compute tail
  endtask

  // leaves valid high; the caller drops it after the last write
  task automatic cfg_write(logic [1:0] idx, logic [22:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgAtomCount: n_atoms = val[6:0];
      CfgRegionX:   box_x = val;
      CfgRegionY:   box_y = val;
      default:      r_cut = val;
    endcase
  endtask

  function automatic lj_in_t mk(logic [1:0] c, logic [5:0] idx, int x, int y);
    lj_in_t b;
    b.cmd = c;
    b.atom_index = idx;
    b.pos_x = x[23:0];
    b.pos_y = y[23:0];
    return b;
  endfunction

  function automatic logic [23:0] rand_coord(logic [22:0] region, logic [23:0] near);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 24'($urandom);
    if (r < 45) return near + 24'($urandom_range(0, 160000)) - 24'd80000;
    return 24'($urandom_range(0, int'(region) - 1));
  endfunction

  // ---------------- stimulus ----------------
  dir_row_t dir_tab[$];
  lj_out_t  nil_out;

  initial begin
    int unsigned burst;
    int unsigned computes;
    logic [23:0] last_x, last_y;
    lj_in_t b;
    lj_out_t want_sat, want_zero;
    logic [6:0]  ph_cnt[7];
    logic [22:0] ph_rx[7];
    logic [22:0] ph_ry[7];
    logic [22:0] ph_rc[7];
    int unsigned ph_comp[7];

    ph_cnt = '{7'd6, 7'd64, 7'd0, 7'd127, 7'd5, 7'd2, 7'd8};
    ph_rx = '{23'd655360, 23'd8388607, 23'd131072, 23'd300000,
              23'd1, 23'd400000, 23'd500000};
    ph_ry = '{23'd655360, 23'd1, 23'd196608, 23'd400000,
              23'd8388607, 23'd250000, 23'd350000};
    ph_rc = '{23'd73562, 23'd0, 23'd8388607, 23'd20000,
              23'd8388607, 23'd150000, 23'd90000};
    ph_comp = '{6, 2, 4, 2, 5, 6, 6};

    nil_out = '0;
    want_zero = '0;
    want_sat = '0;
    want_sat.overflow_flag = 1'b1;
    n_atoms = AtomCountRst;
    box_x = RegionRst;
    box_y = RegionRst;
    r_cut = CutoffRst;
    pot_sum = 0;
    vir_sum = 0;
    sat = 1'b0;
    foreach (acc_x[k]) begin
      acc_x[k] = 0;
      acc_y[k] = 0;
      pos_x[k] = 0;
      pos_y[k] = 0;
    end

    dir_tab = '{
      '{mk(CmdLoad, 0, 0, 0), 0, nil_out},
      '{mk(CmdLoad, 1, 0, 0), 0, nil_out},
      '{mk(CmdCompute, 0, 0, 0), 0, nil_out},
      '{mk(CmdRead, 0, 0, 0), 1, want_sat},        // coincident pair
      '{mk(CmdLoad, 1, 196608, 0), 0, nil_out},
      '{mk(CmdCompute, 0, 0, 0), 0, nil_out},
      '{mk(CmdRead, 1, 0, 0), 1, want_zero},       // beyond cutoff
      '{mk(CmdLoad, 1, 72090, 0), 0, nil_out},
      '{mk(CmdCompute, 0, 0, 0), 0, nil_out},
      '{mk(CmdRead, 0, 0, 0), 0, nil_out},
      '{mk(CmdRead, 1, 0, 0), 0, nil_out},
      '{mk(CmdLoad, 0, -8388608, -8388608), 0, nil_out},
      '{mk(CmdLoad, 1, 8388607, 8388607), 0, nil_out},
      '{mk(CmdCompute, 0, 0, 0), 0, nil_out},
      '{mk(CmdRead, 1, 0, 0), 0, nil_out},
      '{mk(CmdLoad, 1, 625360, 0), 0, nil_out},    // wraps across the box edge
      '{mk(CmdLoad, 0, 20000, 0), 0, nil_out},
      '{mk(CmdCompute, 0, 0, 0), 0, nil_out},
      '{mk(CmdRead, 0, 0, 0), 0, nil_out},
      '{mk(2'd3, 63, -1, -1), 0, nil_out},         // unknown command
      '{mk(CmdLoad, 63, 8388607, -8388608), 0, nil_out},
      '{mk(CmdLoad, 0, 0, 0), 0, nil_out},
      '{mk(CmdLoad, 1, 1, 0), 0, nil_out},         // r^2 of one lsb, saturates
      '{mk(CmdCompute, 0, 0, 0), 0, nil_out},
      '{mk(CmdRead, 1, 0, 0), 0, nil_out},
      '{mk(CmdRead, 63, 0, 0), 0, nil_out}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_tab[k]) begin
      issue(dir_tab[k].beat, dir_tab[k].typed, dir_tab[k].want);
      if ($urandom_range(0, 3) == 0) gap($urandom_range(1, 4));
    end

    // fill every slot so any atom count reads loaded positions only
    for (int k = 0; k < NAtoms; k++)
      issue(mk(CmdLoad, 6'(k), int'($urandom_range(0, 655359)),
               int'($urandom_range(0, 655359))), 0, nil_out);

    last_x = '0;
    last_y = '0;
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      cfg_write(CfgAtomCount, 23'(ph_cnt[ph]));
      cfg_write(CfgRegionX, ph_rx[ph]);
      cfg_write(CfgRegionY, ph_ry[ph]);
      cfg_write(CfgCutoff, ph_rc[ph]);
      cfg_valid_i <= 1'b0;
      @(posedge clk_i);
      computes = 0;
      burst = $urandom_range(1, 12);
      for (int it = 0; it < 27; it++) begin
        int unsigned r;
        int unsigned lim;
        r = $urandom_range(0, 99);
        lim = (ph_cnt[ph] > NAtoms || ph_cnt[ph] < 2) ? NAtoms - 1 : ph_cnt[ph] - 1;
        b.cmd = CmdRead;
        b.atom_index = 6'($urandom);
        b.pos_x = 24'($urandom);
        b.pos_y = 24'($urandom);
        if (r < 45) begin
          b.cmd = CmdLoad;
          if ($urandom_range(0, 4) != 0) b.atom_index = 6'($urandom_range(0, lim));
          b.pos_x = rand_coord(ph_rx[ph], last_x);
          b.pos_y = rand_coord(ph_ry[ph], last_y);
          last_x = b.pos_x;
          last_y = b.pos_y;
        end else if ((r < 60 || it == 20) && computes < ph_comp[ph]) begin
          b.cmd = CmdCompute;
          computes++;
        end else if (r > 94) begin
          b.cmd = 2'd3;
        end
        issue(b, 0, nil_out);
        if (it == 25) drain();
        else if (--burst == 0) begin
          gap($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8));
          burst = $urandom_range(1, 12);
        end
      end
    end

    start <= 1'b0;
    do @(posedge clk_i); while (busy || read_q.size() != 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
